>>> rtl/minutes_seconds_command_parser_assert.svh
// Assertion macros for the parser RTL.
`ifndef MINUTES_SECONDS_COMMAND_PARSER_ASSERT_SVH
`define MINUTES_SECONDS_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSCP_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, checked out of reset.
`define MSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

>>> rtl/mscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscp_pkg
// Types and constants for the minutes:seconds command parser.
// ----------------------------------------------------------------------------
package mscp_pkg;

  localparam int unsigned LINE_CHARS = 8;
  localparam int unsigned HELD_W     = $clog2(LINE_CHARS + 1);
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned SECS_W     = 13;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [9:0] SECONDS_LIMIT = 10'd60;
  localparam logic [9:0] MINUTES_MAX   = 10'd99;
  localparam logic [9:0] DIGIT_BASE    = 10'd10;
  localparam logic [SECS_W-1:0] SECS_PER_MIN = SECS_W'(60);
  localparam logic [SECS_W-1:0] SECS_MAX     = SECS_W'(5999);

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT_POLLS = 1'b0;

  typedef struct packed {
    logic [HELD_W-1:0] held_count;
    logic [7:0]        idle_polls;
    logic [6:0]        minutes_value;
    logic [5:0]        seconds_value;
    logic              colon_seen;
    logic [1:0]        minute_count;
    logic [1:0]        second_count;
    logic              format_error;
  } line_state_t;

  typedef struct packed {
    logic              echo_valid;
    logic [7:0]        echo_byte;
    logic              updated;
    logic [SECS_W-1:0] new_seconds;
  } result_t;

endpackage

>>> rtl/mscp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscp_in_if / mscp_out_if
// Valid/ready channels for input items and result items of the parser.
// ----------------------------------------------------------------------------
interface mscp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface mscp_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic        updated;
  logic [12:0] new_seconds;

  modport source (output valid, output echo_valid, output echo_byte, output updated,
                  output new_seconds, input ready);
  modport sink (input valid, input echo_valid, input echo_byte, input updated,
                input new_seconds, output ready);
endinterface

>>> rtl/minutes_seconds_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minutes_seconds_command_parser
// Parses M[M][:S[S]] and :S[S] lines from serial bytes and poll ticks into seconds.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per handshake: func 0 with a received byte in
//   rx_byte, or func 1 for a poll tick. rsp_o returns exactly one item per
//   input item: the echo (byte items only) and, when a line completes
//   validly on CR/LF or on idle timeout, updated with minutes*60+seconds.
//   The APB port holds timeout_polls at address 0 (reset 100).
// Pipeline: an accepted item is held in the input register, and its result
//   is written to the result register when the item advances; a stall on
//   rsp_o can hold the item in the input register.
// Throughput: one item per cycle while rsp_o is not held off. The line
//   state update (two multiplies by ten, one by sixty, compares) is the
//   combinational logic between the input register and the result register.
// Reset: clears the line state and the valid bits of both pipeline registers;
//   timeout_polls returns to 100.
// Stall: while rsp_o is held off, the result register holds; the input
//   register still takes one more item, then ready drops until space opens.
// ----------------------------------------------------------------------------
`include "minutes_seconds_command_parser_assert.svh"

module minutes_seconds_command_parser
  import mscp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mscp_in_if.sink            req_i,
  mscp_out_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic              in_valid_q;
  logic              in_func_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  result_t           out_q;
  result_t           out_d;
  line_state_t       line_q;
  line_state_t       line_d;
  logic [7:0]        timeout_q;
  logic              advance;
  logic              cfg_wr;
  logic              is_eol;
  logic              is_digit;
  logic              is_colon;
  logic [9:0]        min_v;
  logic [9:0]        sec_v;
  logic [7:0]        idle_inc;
  logic [SECS_W-1:0] total;
  logic              line_ok;
  logic              upd;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_wr && (paddr[2] == REG_TIMEOUT_POLLS)) begin
      timeout_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT_POLLS) begin
      prdata = PDATA_W'(timeout_q);
    end
  end

  // ---------------- handshake ----------------
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_func_q <= req_i.func;
      in_byte_q <= req_i.rx_byte;
    end
  end

  // ---------------- line parsing ----------------
  assign is_eol   = (in_byte_q == CHAR_CR) || (in_byte_q == CHAR_LF);
  assign is_colon = (in_byte_q == CHAR_COLON);
  assign is_digit = (in_byte_q >= CHAR_ZERO) && (in_byte_q <= CHAR_NINE);

  assign min_v    = 10'(line_q.minutes_value) * DIGIT_BASE + 10'(in_byte_q[3:0]);
  assign sec_v    = 10'(line_q.seconds_value) * DIGIT_BASE + 10'(in_byte_q[3:0]);
  assign idle_inc = line_q.idle_polls + 8'd1;
  assign total    = SECS_W'(line_q.minutes_value) * SECS_PER_MIN
                  + SECS_W'(line_q.seconds_value);
  assign line_ok  = !line_q.format_error
                  && !(!line_q.colon_seen && (line_q.minute_count == 2'd0))
                  && !(line_q.colon_seen && (line_q.second_count == 2'd0));

  always_comb begin
    line_d = line_q;
    upd    = 1'b0;
    if (!in_func_q) begin
      if (is_eol) begin
        if (line_q.held_count != '0) begin
          upd    = line_ok;
          line_d = '0;
        end
        line_d.idle_polls = '0;
      end else if (is_digit || is_colon) begin
        if (line_q.held_count < HELD_W'(LINE_CHARS)) begin
          if (!line_q.format_error) begin
            if (is_colon) begin
              if (line_q.colon_seen) begin
                line_d.format_error = 1'b1;
              end else begin
                line_d.colon_seen = 1'b1;
              end
            end else if (line_q.colon_seen) begin
              if ((line_q.second_count >= 2'd2) || (sec_v >= SECONDS_LIMIT)) begin
                line_d.format_error = 1'b1;
              end else begin
                line_d.seconds_value = sec_v[5:0];
                line_d.second_count  = line_q.second_count + 2'd1;
              end
            end else begin
              if ((line_q.minute_count >= 2'd2) || (min_v > MINUTES_MAX)) begin
                line_d.format_error = 1'b1;
              end else begin
                line_d.minutes_value = min_v[6:0];
                line_d.minute_count  = line_q.minute_count + 2'd1;
              end
            end
          end
          line_d.held_count = line_q.held_count + HELD_W'(1);
          line_d.idle_polls = '0;
        end else begin
          // buffer full: drop the whole line
          line_d = '0;
        end
      end else begin
        line_d = '0;
      end
    end else if (line_q.held_count != '0) begin
      line_d.idle_polls = idle_inc;
      if (idle_inc >= timeout_q) begin
        upd    = line_ok;
        line_d = '0;
      end
    end
  end

  always_comb begin
    out_d.echo_valid  = !in_func_q;
    out_d.echo_byte   = in_func_q ? 8'd0 : in_byte_q;
    out_d.updated     = upd;
    out_d.new_seconds = upd ? total : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (advance) begin
      line_q <= line_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.echo_valid  = out_q.echo_valid;
  assign rsp_o.echo_byte   = out_q.echo_byte;
  assign rsp_o.updated     = out_q.updated;
  assign rsp_o.new_seconds = out_q.new_seconds;

  // ---------------- assertions ----------------
  `MSCP_ASSERT(a_held_bound, clk_i, rst_ni, 1'b1,
    line_q.held_count <= HELD_W'(LINE_CHARS))
  `MSCP_ASSERT(a_error_needs_held, clk_i, rst_ni, line_q.format_error,
    line_q.held_count != '0)
  `MSCP_ASSERT(a_stall_blocks_advance, clk_i, rst_ni, out_valid_q && !rsp_o.ready,
    !advance)
  `MSCP_ASSERT_NEXT(a_update_clears_line, clk_i, rst_ni, advance && upd,
    line_q.held_count == '0)
  `MSCP_ASSERT(a_seconds_range, clk_i, rst_ni, out_valid_q && out_q.updated,
    out_q.new_seconds <= SECS_MAX)

endmodule

>>> sim/tb_minutes_seconds_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minutes_seconds_command_parser
// Self-checking bench for the minutes:seconds command parser. A queue-fed
// driver sends bytes and poll ticks, a line predictor works out the echo and
// the parsed time for every accepted item, and a monitor compares each
// result item field by field. Runs directed lines, then random lines, mostly
// well-formed, mixed with noise, across several timeout settings.
// ----------------------------------------------------------------------------
module tb_minutes_seconds_command_parser;
  import mscp_pkg::*;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = {REG_TIMEOUT_POLLS, 2'b00};

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } rx_cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mscp_in_if  req ();
  mscp_out_if rsp ();

  minutes_seconds_command_parser uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rx_cmd_t pending_cmds[$];
  result_t expected_results[$];
  int      err_count = 0;
  int      cmds_pushed = 0;
  int      send_idle_pct = 34;
  int      recv_idle_pct = 60;
  bit      stall_armed = 1'b0;
  bit      stall_done = 1'b0;
  int      hold_left = 0;

  // line predictor state
  logic [7:0] timeout_cfg = TIMEOUT_RESET;
  logic [3:0] held_chars = '0;
  logic [7:0] idle_ticks = '0;
  logic [6:0] min_val = '0;
  logic [5:0] sec_val = '0;
  logic       colon_seen = 1'b0;
  logic [1:0] min_digits = '0;
  logic [1:0] sec_digits = '0;
  logic       bad_format = 1'b0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  function automatic void clear_line();
    held_chars = '0;
    idle_ticks = '0;
    min_val = '0;
    sec_val = '0;
    colon_seen = 1'b0;
    min_digits = '0;
    sec_digits = '0;
    bad_format = 1'b0;
  endfunction

  // Returns {updated, new_seconds} for the held line and clears it.
  function automatic logic [SECS_W:0] close_line();
    logic ok;
    int   total;
    ok = !bad_format;
    if (!colon_seen && min_digits == 0) ok = 1'b0;
    if (colon_seen && sec_digits == 0) ok = 1'b0;
    total = int'(min_val) * 60 + int'(sec_val);
    clear_line();
    return ok ? {1'b1, SECS_W'(total)} : '0;
  endfunction

  function automatic result_t advance_line(logic func, logic [7:0] ch);
    result_t res;
    int      v;
    res = '0;
    if (func == FUNC_BYTE) begin
      res.echo_valid = 1'b1;
      res.echo_byte = ch;
      if (ch == CHAR_CR || ch == CHAR_LF) begin
        if (held_chars != 0) {res.updated, res.new_seconds} = close_line();
        idle_ticks = '0;
      end else if ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_COLON) begin
        if (held_chars < LINE_CHARS) begin
          if (!bad_format) begin
            if (ch == CHAR_COLON) begin
              if (colon_seen) bad_format = 1'b1;
              else colon_seen = 1'b1;
            end else if (colon_seen) begin
              v = int'(sec_val) * 10 + int'(ch) - int'(CHAR_ZERO);
              if (sec_digits >= 2 || v >= int'(SECONDS_LIMIT)) begin
                bad_format = 1'b1;
              end else begin
                sec_val = 6'(v);
                sec_digits++;
              end
            end else begin
              v = int'(min_val) * 10 + int'(ch) - int'(CHAR_ZERO);
              if (min_digits >= 2 || v > int'(MINUTES_MAX)) begin
                bad_format = 1'b1;
              end else begin
                min_val = 7'(v);
                min_digits++;
              end
            end
          end
          held_chars++;
          idle_ticks = '0;
        end else begin
          clear_line();
        end
      end else begin
        clear_line();
      end
    end else if (held_chars != 0) begin
      idle_ticks = idle_ticks + 8'd1;
      if (idle_ticks >= timeout_cfg) {res.updated, res.new_seconds} = close_line();
    end
    return res;
  endfunction

  // driver: present the next pending item, hold it until taken
  always @(posedge clk_i) begin
    if (rst_ni && (!req.valid || req.ready)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_cmd_t c;
        c = pending_cmds.pop_front();
        req.valid <= 1'b1;
        req.func <= c.func;
        req.rx_byte <= c.ch;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready)
      expected_results.push_back(advance_line(req.func, req.rx_byte));
  end

  // receiver: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_armed && !stall_done && pending_cmds.size() > 50) begin
      rsp.ready <= 1'b0;
      hold_left <= 200;
      stall_done <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        result_t want;
        want = expected_results.pop_front();
        if (rsp.echo_valid !== want.echo_valid)
          report_mismatch($sformatf("echo_valid got %0b want %0b",
                                    rsp.echo_valid, want.echo_valid));
        if (rsp.echo_byte !== want.echo_byte)
          report_mismatch($sformatf("echo_byte got %02h want %02h",
                                    rsp.echo_byte, want.echo_byte));
        if (rsp.updated !== want.updated)
          report_mismatch($sformatf("updated got %0b want %0b",
                                    rsp.updated, want.updated));
        if (rsp.new_seconds !== want.new_seconds)
          report_mismatch($sformatf("new_seconds got %0d want %0d",
                                    rsp.new_seconds, want.new_seconds));
      end
    end
  end

  task automatic push_cmd(input logic func, input logic [7:0] ch);
    rx_cmd_t c;
    c.func = func;
    c.ch = ch;
    pending_cmds.push_back(c);
    cmds_pushed++;
  endtask

  task automatic push_poll();
    push_cmd(FUNC_POLL, 8'($urandom_range(255)));
  endtask

  task automatic push_text(input string body, input logic [7:0] term);
    for (int i = 0; i < body.len(); i++) push_cmd(FUNC_BYTE, body[i]);
    push_cmd(FUNC_BYTE, term);
  endtask

  // digit or colon, sometimes followed by polls that stay short of the timeout
  task automatic push_held(input logic [7:0] ch);
    int gap;
    push_cmd(FUNC_BYTE, ch);
    if (timeout_cfg > 1 && $urandom_range(9) == 0) begin
      gap = (timeout_cfg > 4) ? 3 : int'(timeout_cfg) - 1;
      repeat ($urandom_range(1, gap)) push_poll();
    end
  endtask

  task automatic end_line();
    int pick;
    int tmo_pct;
    pick = $urandom_range(99);
    tmo_pct = (timeout_cfg <= 12) ? 30 : 3;
    if (pick < tmo_pct)
      repeat (timeout_cfg) push_poll();
    else if (pick < 92)
      push_cmd(FUNC_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic push_random_line();
    int  pick;
    int  n_min;
    int  n_sec;
    int  len;
    bit  with_colon;
    pick = $urandom_range(99);
    if (pick < 75) begin
      n_min = $urandom_range(2);
      with_colon = 1'($urandom_range(1));
      n_sec = with_colon ? $urandom_range(2) : 0;
      repeat (n_min) push_held(CHAR_ZERO + 8'($urandom_range(9)));
      if (with_colon) push_held(CHAR_COLON);
      for (int i = 0; i < n_sec; i++) begin
        // keep the tens digit of seconds mostly below six
        if (i == 0 && $urandom_range(4) != 0)
          push_held(CHAR_ZERO + 8'($urandom_range(5)));
        else
          push_held(CHAR_ZERO + 8'($urandom_range(9)));
      end
      end_line();
    end else if (pick < 87) begin
      push_cmd(FUNC_BYTE, 8'($urandom_range(255)));
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 3)) push_poll();
    end else begin
      len = $urandom_range(1, LINE_CHARS + 3);
      repeat (len)
        push_held(($urandom_range(3) == 0) ? CHAR_COLON : CHAR_ZERO + 8'($urandom_range(9)));
      end_line();
    end
  endtask

  task automatic push_random(input int count);
    int target;
    target = cmds_pushed + count;
    while (cmds_pushed < target) push_random_line();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || req.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TIMEOUT;
    pwdata <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    timeout_cfg = val;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.func = FUNC_BYTE;
    req.rx_byte = '0;
    rsp.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed lines at the reset timeout
    push_text("99:59", CHAR_CR);
    push_text("100", CHAR_CR);
    push_text(":60", CHAR_LF);
    push_text("1::2", CHAR_CR);
    push_text(":", CHAR_CR);
    push_text("", CHAR_CR);
    push_text("5A", CHAR_CR);
    push_random(150);
    wait_drained();

    write_timeout(8'd1);
    push_text("5", 8'h00);
    push_poll();
    push_random(150);
    wait_drained();

    send_idle_pct = 60;
    recv_idle_pct = 34;
    write_timeout(8'd255);
    push_cmd(FUNC_BYTE, CHAR_ZERO + 8'd3);
    repeat (255) push_poll();
    push_random(100);
    wait_drained();

    write_timeout(8'($urandom_range(2, 12)));
    push_random(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(8'd6);
    push_random(150);
    stall_armed = 1'b1;
    wait_drained();

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mscp_pkg.sv
rtl/mscp_if.sv
rtl/minutes_seconds_command_parser.sv
sim/tb_minutes_seconds_command_parser.sv
